/* rtl/pcmf_pkg.sv */
package pcmf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int EXP_W    = 8;
    localparam int FRAC_W   = 23;
    localparam int LZ_W     = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENCODING   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_BITS = 3'd1;

    // encodings
    localparam logic [2:0] ENC_FLOAT32 = 3'd0;
    localparam logic [2:0] ENC_PCM16   = 3'd1;
    localparam logic [2:0] ENC_PCM24   = 3'd2;
    localparam logic [2:0] ENC_PCM32   = 3'd3;

    localparam logic [5:0] VBITS_RESET = 6'd32;

    // exponent of bit 31 with bias: 127 + 31
    localparam logic [8:0] EXP_TOP = 9'd158;

    typedef struct packed {
        logic                  sign;
        logic                  zero;
        logic                  bypass;
        logic [EXP_W-1:0]      exp;
        logic [SAMPLE_W-1:0]   norm;
        logic [SAMPLE_W-1:0]   bdata;
    } t_pack_in;

endpackage

/* rtl/pcmf_if.sv */
interface pcmf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_sample;
    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface pcmf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_float;
    modport source (output valid, output sample_float, input ready);
    modport sink   (input valid, input sample_float, output ready);
endinterface

interface pcmf_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] reg_index;
    logic [5:0] wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* rtl/pcmf_round_pack.sv */
module pcmf_round_pack (
    input  pcmf_pkg::t_pack_in i_p,
    output logic [31:0]        o_bits
);
    import pcmf_pkg::*;

    logic                   w_inc;
    logic [EXP_W+FRAC_W-1:0] w_body;

    always_comb begin
        // round to nearest even on guard / sticky / lsb
        w_inc  = i_p.norm[7] & ((|i_p.norm[6:0]) | i_p.norm[8]);
        // mantissa carry ripples into the exponent
        w_body = {i_p.exp, i_p.norm[30:8]} + {{(EXP_W+FRAC_W-1){1'b0}}, w_inc};
        if (i_p.bypass) begin
            o_bits = i_p.bdata;
        end else if (i_p.zero) begin
            o_bits = '0;
        end else begin
            o_bits = {i_p.sign, w_body};
        end
    end
endmodule

/* rtl/pcm_sample_to_float32_core.sv */
// Four register stages lie between input transfer and result valid.
// Throughput: one sample per cycle while the output is ready; each stage holds one item with its own valid bit.
// A stalled output lets upstream stages fill before input ready drops.
// Reset (i_rst_n low, synchronous): valid bits cleared, encoding = float32,
// valid bits = 32. Payload registers are not reset.
module pcm_sample_to_float32_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pcmf_in_if.sink           i_sample,
    pcmf_out_if.source        o_sample,
    pcmf_cfg_if.sink          i_cfg
);
    import pcmf_pkg::*;

    // ---------------- configuration ----------------
    logic [2:0] r_enc;
    logic [5:0] r_vbits;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc   <= ENC_FLOAT32;
            r_vbits <= VBITS_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == REG_ENCODING) begin
                r_enc <= i_cfg.wr_data[2:0];
            end
            if (i_cfg.reg_index == REG_VALID_BITS) begin
                r_vbits <= i_cfg.wr_data;
            end
        end
    end

    // ---------------- stage enables ----------------
    // Each stage loads when it is empty or its content moves on.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4 = !r_v4 || o_sample.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_sample.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_sample.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: decode to integer and scale ----------------
    // value = X * 2^-s
    logic [5:0]          w_vc;
    logic [4:0]          w_sh;
    logic signed [31:0]  n_x;
    logic [4:0]          n_s;
    logic                n_byp;
    logic [31:0]         n_bdata;

    logic signed [31:0]  r_x1;
    logic [4:0]          r_s1;
    logic                r_byp1;
    logic [31:0]         r_bdata1;

    always_comb begin
        // clamp valid bits to 1..32
        if (r_vbits == 6'd0) begin
            w_vc = 6'd1;
        end else if (r_vbits > 6'd32) begin
            w_vc = 6'd32;
        end else begin
            w_vc = r_vbits;
        end
        w_sh    = 5'(6'd32 - w_vc);
        n_x     = '0;
        n_s     = '0;
        n_byp   = 1'b0;
        n_bdata = '0;
        case (r_enc)
            ENC_FLOAT32: begin
                n_byp   = 1'b1;
                n_bdata = i_sample.raw_sample;
            end
            ENC_PCM16: begin
                n_x = {{16{i_sample.raw_sample[15]}}, i_sample.raw_sample[15:0]};
                n_s = 5'd15;
            end
            ENC_PCM24: begin
                n_x = {{8{i_sample.raw_sample[23]}}, i_sample.raw_sample[23:0]};
                n_s = 5'd23;
            end
            ENC_PCM32: begin
                n_x = $signed(i_sample.raw_sample) >>> w_sh;
                n_s = 5'(w_vc - 6'd1);
            end
            default: begin
                // unsupported encoding gives +0.0
                n_byp = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_x1     <= n_x;
            r_s1     <= n_s;
            r_byp1   <= n_byp;
            r_bdata1 <= n_bdata;
        end
    end

    // ---------------- stage 2: magnitude and leading zeros ----------------
    logic [31:0]     n_mag;
    logic [LZ_W-1:0] n_lz;
    logic [31:0]     r_mag2;
    logic [LZ_W-1:0] r_lz2;
    logic            r_sign2;
    logic [4:0]      r_s2;
    logic            r_byp2;
    logic [31:0]     r_bdata2;

    always_comb begin
        n_mag = r_x1[31] ? 32'(-r_x1) : r_x1;
        n_lz  = '0;
        for (int i = 0; i < 32; i++) begin
            if (n_mag[i]) n_lz = LZ_W'(31 - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_mag2   <= n_mag;
            r_lz2    <= n_lz;
            r_sign2  <= r_x1[31];
            r_s2     <= r_s1;
            r_byp2   <= r_byp1;
            r_bdata2 <= r_bdata1;
        end
    end

    // ---------------- stage 3: normalize, exponent ----------------
    t_pack_in n_p3;
    t_pack_in r_p3;

    always_comb begin
        n_p3.sign   = r_sign2;
        n_p3.zero   = (r_mag2 == '0);
        n_p3.bypass = r_byp2;
        n_p3.bdata  = r_bdata2;
        n_p3.norm   = r_mag2 << r_lz2;
        n_p3.exp    = EXP_W'(EXP_TOP - {4'd0, r_lz2} - {4'd0, r_s2});
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_p3 <= n_p3;
        end
    end

    // ---------------- stage 4: round and pack into output register ----------------
    logic [31:0] w_bits;
    logic [31:0] r_out4;

    pcmf_round_pack u_round (
        .i_p    (r_p3),
        .o_bits (w_bits)
    );

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out4 <= w_bits;
        end
    end

    assign o_sample.valid        = r_v4;
    assign o_sample.sample_float = r_out4;

endmodule

/* rtl/pcmf_checker.sv */
module pcmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data,
    input logic        i_cfg_ready
);
    logic [2:0] r_cnt;
    logic       w_in_xfer;
    logic       w_out_xfer;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 3'(w_in_xfer) - 3'(w_out_xfer);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_max_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("more items in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 3'd0)
        else $error("result without an accepted sample");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready && i_cfg_ready)
        else $error("input blocked with empty output stage");

endmodule

bind pcm_sample_to_float32_core pcmf_checker u_pcmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_sample.valid),
    .i_out_ready (o_sample.ready),
    .i_out_data  (o_sample.sample_float),
    .i_cfg_ready (i_cfg.ready)
);

/* tb/pcmf_if.sv */
`timescale 1ns / 100ps

// The interfaces come from the RTL file rtl/pcmf_if.sv. They are not declared
// here again: a second declaration would clash with the RTL.
// This file stays empty so that the build order does not change.

/* tb/pcm_sample_to_float32_core_tb.sv */
`timescale 1ns / 100ps

// Sample-to-float converter: bit-exact check of every result against an
// integer model of the conversion with round-to-nearest-even.
// Random valid/ready gaps are applied on the input, output and config channels.

import pcmf_pkg::*;

class float_scoreboard;
    logic [2:0]  encoding;
    logic [5:0]  vbits;
    logic [31:0] pending[$];
    int          mismatches;

    function new();
        encoding   = ENC_FLOAT32;
        vbits      = VBITS_RESET;
        mismatches = 0;
    endfunction

    // Round a signed integer divided by 2^scale to single precision (nearest even).
    function logic [31:0] int_to_float(longint val, int scale);
        logic        sgn;
        logic [63:0] mag, keep, rem, half;
        int          msb, sh;
        logic [8:0]  ex;
        sgn = (val < 0);
        mag = sgn ? -val : val;
        if (mag == 0)
            return 32'h0;
        msb = 0;
        for (int b = 0; b < 64; b++)
            if (mag[b]) msb = b;
        ex = 9'(msb - scale + 127);
        if (msb <= 23) begin
            keep = mag << (23 - msb);
        end else begin
            sh   = msb - 23;
            keep = mag >> sh;
            rem  = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0]))
                keep = keep + 1;
            if (keep[24]) begin
                keep = keep >> 1;
                ex   = ex + 1;
            end
        end
        return {sgn, ex[7:0], keep[22:0]};
    endfunction

    function logic [31:0] convert(logic [31:0] raw);
        int vb;
        logic signed [31:0] top;
        case (encoding)
            ENC_FLOAT32: return raw;
            ENC_PCM16:   return int_to_float(longint'($signed(raw[15:0])), 15);
            ENC_PCM24:   return int_to_float(longint'($signed(raw[23:0])), 23);
            ENC_PCM32: begin
                vb = vbits;
                if (vb < 1)  vb = 1;
                if (vb > 32) vb = 32;
                top = $signed(raw) >>> (32 - vb);   // keeps the top vb bits, sign-extended
                return int_to_float(longint'(top), vb - 1);
            end
            default:     return 32'h0;
        endcase
    endfunction

    function void set_reg(logic [2:0] idx, logic [5:0] data);
        if (idx == REG_ENCODING)
            encoding = data[2:0];
        else if (idx == REG_VALID_BITS)
            vbits = data;
    endfunction

    function void note_sample(logic [31:0] raw);
        pending.push_back(convert(raw));
    endfunction

    function void check_float(logic [31:0] got);
        logic [31:0] want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("sample_float mismatch: expected %h actual %h", want, got);
        end
    endfunction
endclass

module pcm_sample_to_float32_core_tb;

    logic i_clk;
    logic i_rst_n;

    pcmf_in_if  s_in();
    pcmf_out_if s_out();
    pcmf_cfg_if s_cfg();

    float_scoreboard sb = new();

    // when set, no side inserts idle cycles
    bit no_idle;
    int out_stall;

    pcm_sample_to_float32_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (s_in),
        .o_sample (s_out),
        .i_cfg    (s_cfg)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // Output side: check each transfer, then stall a random number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_out.valid && s_out.ready) begin
                sb.check_float(s_out.sample_float);
                out_stall = draw_gap();
            end else if (out_stall > 0) begin
                out_stall--;
            end
            s_out.ready <= (out_stall == 0) && !(s_out.valid && s_out.ready && out_stall != 0);
        end
    end

    task automatic send_sample(logic [31:0] raw);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_in.valid      <= 1'b1;
        s_in.raw_sample <= raw;
        do @(posedge i_clk); while (!s_in.ready);
        sb.note_sample(raw);
    endtask

    // valid stays high after the transfer; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [5:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_cfg.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_cfg.valid     <= 1'b1;
        s_cfg.reg_index <= idx;
        s_cfg.wr_data   <= data;
        do @(posedge i_clk); while (!s_cfg.ready);
        sb.set_reg(idx, data);
    endtask

    // Wait until every expected result is back, plus the pipeline latency.
    task automatic drain();
        s_in.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function logic [31:0] random_raw();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: r = {32{r[0]}} ^ 32'($urandom_range(0, 3));   // around zero / minus one
            1: r = {r[31], {31{r[30]}}};                     // full-scale ends
            2: r = r & 32'h0000_ffff;
            3: r = {{8{r[23]}}, r[23:0]};
            default: ;
        endcase
        return r;
    endfunction

    localparam int N_DIR = 12;
    logic [31:0] directed [N_DIR] = '{
        32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
        32'h0000_8000, 32'h0000_7fff, 32'h0080_0000, 32'h007f_ffff,
        32'h7fc0_0001, 32'hff80_0000, 32'h0000_0001, 32'h0000_0180
    };

    // encoding / valid-bits pairs per phase; the extremes come first
    localparam int N_PH = 18;
    logic [2:0] ph_enc [N_PH] = '{ENC_FLOAT32, ENC_PCM16, ENC_PCM24, ENC_PCM32, ENC_PCM32,
                                  ENC_PCM32, ENC_PCM32, ENC_PCM32, ENC_PCM32, ENC_PCM32,
                                  ENC_PCM32, 3'd4, 3'd7, 3'd5, 3'd6, ENC_PCM32,
                                  ENC_PCM32, ENC_PCM16};
    logic [5:0] ph_vb [N_PH] = '{6'd32, 6'd0, 6'd63, 6'd32, 6'd1, 6'd0, 6'd63, 6'd33,
                                 6'd24, 6'd25, 6'd16, 6'd7, 6'd42, 6'd21, 6'd2,
                                 6'd0, 6'd0, 6'd32};

    initial begin
        logic [5:0] vb;
        i_rst_n         = 1'b0;
        s_in.valid      = 1'b0;
        s_in.raw_sample = '0;
        s_cfg.valid     = 1'b0;
        s_cfg.reg_index = '0;
        s_cfg.wr_data   = '0;
        s_out.ready     = 1'b0;
        out_stall       = 0;
        no_idle         = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting (float passthrough) gets a short look first
        for (int i = 0; i < N_DIR; i++) send_sample(directed[i]);
        drain();

        for (int p = 0; p < N_PH; p++) begin
            vb = ph_vb[p];
            if (p == 15 || p == 16) vb = 6'($urandom_range(1, 32));
            write_reg(REG_ENCODING, ph_enc[p]);
            write_reg(REG_VALID_BITS, vb);
            s_cfg.valid <= 1'b0;
            no_idle = (p % 4 == 2);
            for (int i = 0; i < N_DIR; i++) send_sample(directed[i]);
            for (int i = 0; i < 75; i++) begin
                if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_sample(random_raw());
            end
            no_idle = 1'b0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("pcm_sample_to_float32_core_tb passed");
        end else begin
            $display("pcm_sample_to_float32_core_tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("pcm_sample_to_float32_core_tb failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pcmf_pkg.sv
rtl/pcmf_if.sv
rtl/pcmf_round_pack.sv
rtl/pcm_sample_to_float32_core.sv
rtl/pcmf_checker.sv
tb/pcmf_if.sv
tb/pcm_sample_to_float32_core_tb.sv
